FILE: src/gbn_pkg.sv
package gbn_pkg;

	// Sequence numbers and header fields are fixed at sixteen bits
	localparam int SEQ_WIDTH = 16;
	localparam int WIN_WIDTH = 7;
	localparam int MAX_WINDOW_DEF = 64;
	// Longest retransmit run handed out for one timeout
	localparam int RESULT_CAP = 64;

	localparam logic [WIN_WIDTH-1:0] WINDOW_SIZE_RST = 7'd10;
	localparam logic [SEQ_WIDTH-1:0] TOTAL_PACKETS_RST = 16'd1;

	// Event codes carried in tuser
	localparam logic [1:0] FUNC_SEND    = 2'd0;
	localparam logic [1:0] FUNC_ACK     = 2'd1;
	localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_WINDOW_SIZE   = 2'd0;
	localparam logic [1:0] REG_TOTAL_PACKETS = 2'd1;

	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 24;

	typedef struct packed {
		logic accept;   // load a new event into the datapath
		logic step;     // emit the next retransmission of a run
	} gbn_cmd_t;

	typedef struct packed {
		logic out_free;  // output register empty or being taken
		logic run_start; // event in flight starts a run of several beats
		logic step_last; // the next run beat is its final one
	} gbn_status_t;

endpackage

FILE: src/gbn_ctrl.sv
module gbn_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  gbn_pkg::gbn_status_t status,
	output gbn_pkg::gbn_cmd_t    cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t state_q;

	// Accept only when idle and the output register can take a beat
	always_comb begin
		s_tready   = (state_q == ST_IDLE) && status.out_free;
		cmd.accept = s_tready && s_tvalid;
		cmd.step   = (state_q == ST_RUN) && status.out_free;
	end

	// Hold in the run state until its last retransmission is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.accept && status.run_start) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd.step && status.step_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: src/gbn_datapath.sv
module gbn_datapath #(
	parameter int MAX_WINDOW = gbn_pkg::MAX_WINDOW_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gbn_pkg::gbn_cmd_t              cmd,
	output gbn_pkg::gbn_status_t           status,
	input  logic [1:0]                     func,
	input  logic [gbn_pkg::SEQ_WIDTH-1:0]  ack_number,
	input  logic [gbn_pkg::SEQ_WIDTH-1:0]  ack_sequence,
	input  logic                           ack_last_flag,
	input  logic [gbn_pkg::SEQ_WIDTH-1:0]  ack_length,
	input  logic [gbn_pkg::SEQ_WIDTH-1:0]  ack_check,
	input  logic                           cfg_valid,
	input  logic [1:0]                     cfg_index,
	input  logic [gbn_pkg::SEQ_WIDTH-1:0]  cfg_data,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic                           send_valid,
	output logic [gbn_pkg::SEQ_WIDTH-1:0]  send_seq,
	output logic                           is_resend,
	output logic                           bad_checksum,
	output logic                           finished,
	output logic                           last_of_run
);

	localparam int SW = gbn_pkg::SEQ_WIDTH;
	localparam int RUN_CAP = (MAX_WINDOW < gbn_pkg::RESULT_CAP) ? MAX_WINDOW
		: gbn_pkg::RESULT_CAP;
	localparam int CNT_W = $clog2(RUN_CAP + 1);
	localparam int MW_W = $clog2(MAX_WINDOW + 1) > gbn_pkg::WIN_WIDTH
		? $clog2(MAX_WINDOW + 1) : gbn_pkg::WIN_WIDTH;

	logic [gbn_pkg::WIN_WIDTH-1:0] win_size_q;
	logic [SW-1:0]                 total_q;
	logic [SW-1:0]                 base_q;
	logic [SW-1:0]                 next_q;
	logic                          done_q;
	logic [CNT_W-1:0]              run_len_q;
	logic [CNT_W-1:0]              run_idx_q;
	logic                          out_valid_q;
	logic                          send_valid_q;
	logic [SW-1:0]                 send_seq_q;
	logic                          is_resend_q;
	logic                          bad_q;
	logic                          fin_q;
	logic                          last_q;

	logic [MW_W-1:0]  win_eff;
	logic [SW:0]      win_limit;
	logic             fin_now;
	logic             can_send;
	logic             ack_bad;
	logic             fin_after_ack;
	logic [SW-1:0]    diff;
	logic [CNT_W-1:0] run_n;
	logic [CNT_W-1:0] idx_inc;

	// Window test, finished test, header check and run length
	always_comb begin
		win_eff = (MW_W'(win_size_q) > MW_W'(MAX_WINDOW))
			? MW_W'(MAX_WINDOW) : MW_W'(win_size_q);
		win_limit = {1'b0, base_q} + (SW+1)'(win_eff);
		fin_now = done_q || (({1'b0, base_q} + (SW+1)'(1)) >= {1'b0, total_q});
		can_send = ({1'b0, next_q} < win_limit) && (next_q < total_q);
		ack_bad = (ack_sequence ^ ack_number ^ {{(SW-1){1'b0}}, ack_last_flag}
			^ ack_length) != ack_check;
		fin_after_ack = done_q || (({1'b0, ack_number} + (SW+1)'(1)) >= {1'b0, total_q});
		diff = (next_q > base_q) ? (next_q - base_q) : '0;
		run_n = (diff > SW'(RUN_CAP)) ? CNT_W'(RUN_CAP) : CNT_W'(diff);
		idx_inc = run_idx_q + CNT_W'(1);
		status.out_free  = !out_valid_q || out_ready;
		status.run_start = !fin_now && (func == gbn_pkg::FUNC_TIMEOUT)
			&& (run_n > CNT_W'(1));
		status.step_last = (idx_inc == run_len_q);
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_size_q <= gbn_pkg::WINDOW_SIZE_RST;
			total_q    <= gbn_pkg::TOTAL_PACKETS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				gbn_pkg::REG_WINDOW_SIZE:   win_size_q <= cfg_data[gbn_pkg::WIN_WIDTH-1:0];
				gbn_pkg::REG_TOTAL_PACKETS: total_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Window state, run counter and output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			next_q      <= '0;
			done_q      <= 1'b0;
			run_len_q   <= '0;
			run_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				out_valid_q <= 1'b1;
				if (fin_now) begin
					done_q <= 1'b1;
				end else begin
					case (func)
						gbn_pkg::FUNC_SEND: begin
							if (can_send) begin
								next_q <= next_q + SW'(1);
							end
						end
						gbn_pkg::FUNC_ACK: begin
							if (!ack_bad) begin
								base_q <= ack_number;
								if (fin_after_ack) begin
									done_q <= 1'b1;
								end
							end
						end
						gbn_pkg::FUNC_TIMEOUT: begin
							run_len_q <= run_n;
							run_idx_q <= CNT_W'(1);
						end
						default: ;
					endcase
				end
			end else if (cmd.step) begin
				out_valid_q <= 1'b1;
				run_idx_q   <= idx_inc;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			send_valid_q <= 1'b0;
			send_seq_q   <= '0;
			is_resend_q  <= 1'b0;
			bad_q        <= 1'b0;
			fin_q        <= 1'b0;
			last_q       <= 1'b1;
			if (fin_now) begin
				fin_q <= 1'b1;
			end else begin
				case (func)
					gbn_pkg::FUNC_SEND: begin
						fin_q <= fin_now;
						if (can_send) begin
							send_valid_q <= 1'b1;
							send_seq_q   <= next_q;
						end
					end
					gbn_pkg::FUNC_ACK: begin
						bad_q <= ack_bad;
						fin_q <= ack_bad ? fin_now : fin_after_ack;
					end
					gbn_pkg::FUNC_TIMEOUT: begin
						if (run_n != '0) begin
							send_valid_q <= 1'b1;
							send_seq_q   <= base_q;
							is_resend_q  <= 1'b1;
							last_q       <= (run_n == CNT_W'(1));
						end
					end
					default: ;
				endcase
			end
		end else if (cmd.step) begin
			send_valid_q <= 1'b1;
			send_seq_q   <= base_q + SW'(run_idx_q);
			is_resend_q  <= 1'b1;
			bad_q        <= 1'b0;
			fin_q        <= 1'b0;
			last_q       <= (idx_inc == run_len_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign send_valid   = send_valid_q;
	assign send_seq     = send_seq_q;
	assign is_resend    = is_resend_q;
	assign bad_checksum = bad_q;
	assign finished     = fin_q;
	assign last_of_run  = last_q;

endmodule

FILE: src/go_back_n_sender_window.sv
// Channel   Direction  Signals                     Content
// s_*       in         tvalid tready tdata tuser   one protocol event
// m_*       out        tvalid tready tdata tlast   one result beat
// cfg_*     in         valid ready index data      register write
//
// Send, ack and unknown events each give one beat.
// A timeout gives one beat per outstanding packet from base, at most the smaller
// of MAX_WINDOW and 64, or a single beat when none is outstanding; one beat goes
// out per cycle while m_tready is high, and the run counter sets the count.
// The next event is taken once the last beat of a run is in the output
// register. Stalls on m_tready hold the output register and the run.
// Reset clears window state and loads default register values at once.
module go_back_n_sender_window #(
	parameter int MAX_WINDOW = gbn_pkg::MAX_WINDOW_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// ack_number, ack_sequence, ack_last_flag, ack_length, ack_check, zero pad
	input  logic [gbn_pkg::IN_TDATA_W-1:0]  s_tdata,
	// func
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// send_valid, send_seq, is_resend, bad_checksum, finished, zero pad
	output logic [gbn_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                            m_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [1:0]                      cfg_index,
	input  logic [gbn_pkg::SEQ_WIDTH-1:0]   cfg_data
);

	gbn_pkg::gbn_cmd_t    cmd;
	gbn_pkg::gbn_status_t status;

	logic                          send_valid;
	logic [gbn_pkg::SEQ_WIDTH-1:0] send_seq;
	logic                          is_resend;
	logic                          bad_checksum;
	logic                          finished;

	assign cfg_ready = 1'b1;

	gbn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	gbn_datapath #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.func          (s_tuser),
		.ack_number    (s_tdata[15:0]),
		.ack_sequence  (s_tdata[31:16]),
		.ack_last_flag (s_tdata[32]),
		.ack_length    (s_tdata[48:33]),
		.ack_check     (s_tdata[64:49]),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_ready     (m_tready),
		.out_valid     (m_tvalid),
		.send_valid    (send_valid),
		.send_seq      (send_seq),
		.is_resend     (is_resend),
		.bad_checksum  (bad_checksum),
		.finished      (finished),
		.last_of_run   (m_tlast)
	);

	// Pack the result beat
	assign m_tdata = {4'b0000, finished, bad_checksum, is_resend, send_seq, send_valid};

endmodule
